### hdl/bsc_pkg.sv
// ----------------------------------------------------------------------------
// bsc_pkg
// Shared types and constants for the resource safety check block: field
// widths and the command/status words between controller and datapath.
// ----------------------------------------------------------------------------
package bsc_pkg;

    // Fixed field widths
    localparam int DATA_W    = 8;
    localparam int PID_W     = 3;
    localparam int RES_SLOTS = 3;

    // Input word kinds
    localparam logic KIND_LOAD  = 1'b0;
    localparam logic KIND_CHECK = 1'b1;

    // Commands from controller to datapath
    typedef struct packed {
        logic load;         // write one process row
        logic init;         // restart the check from the available vector
        logic scan;         // evaluate one process, advance the scan index
        logic emit_safe;    // put out the next sequence entry
        logic emit_unsafe;  // put out the single unsafe word
    } bsc_cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic all_fin;      // the process under scan is the last to finish
        logic pass_fail;    // end of a pass that finished nothing
        logic emit_last;    // the sequence entry being put out is the final one
    } bsc_status_t;

endpackage

### hdl/bankers_safety_check_top.sv
// A load word is written at its accepting edge and gives no result. A check scans one
// process per cycle, in at most NUM_PROCS passes; its result words leave the result
// register after the controller enters an emit state, one per cycle (NUM_PROCS safe
// words, or one unsafe word). The receiver cannot stall.
// Loads are taken one per cycle; busy is high through the scan and emit states, so no
// new word is taken during a check. Reset clears the process tables, the scan state
// and the result strobe.
// ----------------------------------------------------------------------------
// bankers_safety_check_top
// Resource safety check over a small process table: load rows, then run
// the check and put out the safe sequence or a single unsafe word.
// ----------------------------------------------------------------------------
module bankers_safety_check_top #(
    parameter int NUM_PROCS = 5,
    parameter int NUM_RES   = 3
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic                        kind,
    input  logic [bsc_pkg::PID_W-1:0]   process_index,
    input  logic [bsc_pkg::DATA_W-1:0]  max_r0,
    input  logic [bsc_pkg::DATA_W-1:0]  max_r1,
    input  logic [bsc_pkg::DATA_W-1:0]  max_r2,
    input  logic [bsc_pkg::DATA_W-1:0]  alloc_r0,
    input  logic [bsc_pkg::DATA_W-1:0]  alloc_r1,
    input  logic [bsc_pkg::DATA_W-1:0]  alloc_r2,
    input  logic [bsc_pkg::DATA_W-1:0]  avail_r0,
    input  logic [bsc_pkg::DATA_W-1:0]  avail_r1,
    input  logic [bsc_pkg::DATA_W-1:0]  avail_r2,
    output logic                        result_strobe,
    output logic                        is_safe,
    output logic [bsc_pkg::PID_W-1:0]   process_id,
    output logic                        last
);
    import bsc_pkg::*;

    bsc_cmd_t    cmd;
    bsc_status_t status;

    logic [DATA_W-1:0] max_in   [RES_SLOTS];
    logic [DATA_W-1:0] alloc_in [RES_SLOTS];
    logic [DATA_W-1:0] avail_in [RES_SLOTS];

    // Gather the resource fields into lanes
    assign max_in[0]   = max_r0;
    assign max_in[1]   = max_r1;
    assign max_in[2]   = max_r2;
    assign alloc_in[0] = alloc_r0;
    assign alloc_in[1] = alloc_r1;
    assign alloc_in[2] = alloc_r2;
    assign avail_in[0] = avail_r0;
    assign avail_in[1] = avail_r1;
    assign avail_in[2] = avail_r2;

    bsc_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .kind   (kind),
        .status (status),
        .cmd    (cmd),
        .busy   (busy)
    );

    bsc_datapath #(
        .NUM_PROCS (NUM_PROCS),
        .NUM_RES   (NUM_RES)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .process_index (process_index),
        .max_in        (max_in),
        .alloc_in      (alloc_in),
        .avail_in      (avail_in),
        .result_strobe (result_strobe),
        .is_safe       (is_safe),
        .process_id    (process_id),
        .last          (last)
    );

endmodule

### hdl/bsc_ctrl.sv
// ----------------------------------------------------------------------------
// bsc_ctrl
// Controller for the safety check: accepts words, sequences the scan
// passes and the result words, and drives busy.
// ----------------------------------------------------------------------------
module bsc_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic                 kind,
    input  bsc_pkg::bsc_status_t status,
    output bsc_pkg::bsc_cmd_t    cmd,
    output logic                 busy
);
    import bsc_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_EMIT_SAFE,
        ST_EMIT_UNSAFE
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   busy_reg;
    logic   busy_next;
    logic   accept;

    assign accept = start && !busy_reg;
    assign busy   = busy_reg;

    // Decode commands and next state
    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        busy_next  = busy_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && (kind == KIND_LOAD))
                begin
                    cmd.load = 1'b1;
                end
                if (accept && (kind == KIND_CHECK))
                begin
                    cmd.init   = 1'b1;
                    state_next = ST_SCAN;
                    busy_next  = 1'b1;
                end
            end
            ST_SCAN:
            begin
                cmd.scan = 1'b1;
                if (status.all_fin)
                begin
                    state_next = ST_EMIT_SAFE;
                end
                else if (status.pass_fail)
                begin
                    state_next = ST_EMIT_UNSAFE;
                end
            end
            ST_EMIT_SAFE:
            begin
                cmd.emit_safe = 1'b1;
                if (status.emit_last)
                begin
                    state_next = ST_IDLE;
                    busy_next  = 1'b0;
                end
            end
            ST_EMIT_UNSAFE:
            begin
                cmd.emit_unsafe = 1'b1;
                state_next      = ST_IDLE;
                busy_next       = 1'b0;
            end
            default:
            begin
                state_next = ST_IDLE;
                busy_next  = 1'b0;
            end
        endcase
    end

    // Hold state and busy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            busy_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            busy_reg  <= busy_next;
        end
    end

endmodule

### hdl/bsc_datapath.sv
// ----------------------------------------------------------------------------
// bsc_datapath
// Process tables, working vector, finished flags, sequence store and the
// registered result word. One process is evaluated per scan cycle with all
// resources compared side by side.
// ----------------------------------------------------------------------------
module bsc_datapath #(
    parameter int NUM_PROCS = 5,
    parameter int NUM_RES   = 3
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  bsc_pkg::bsc_cmd_t         cmd,
    output bsc_pkg::bsc_status_t      status,
    input  logic [bsc_pkg::PID_W-1:0] process_index,
    input  logic [bsc_pkg::DATA_W-1:0] max_in   [bsc_pkg::RES_SLOTS],
    input  logic [bsc_pkg::DATA_W-1:0] alloc_in [bsc_pkg::RES_SLOTS],
    input  logic [bsc_pkg::DATA_W-1:0] avail_in [bsc_pkg::RES_SLOTS],
    output logic                      result_strobe,
    output logic                      is_safe,
    output logic [bsc_pkg::PID_W-1:0] process_id,
    output logic                      last
);
    import bsc_pkg::*;

    localparam int PIDX_W = (NUM_PROCS > 1) ? $clog2(NUM_PROCS) : 1;
    localparam int CNT_W  = $clog2(NUM_PROCS + 1);
    localparam int WORK_W = DATA_W + $clog2(NUM_PROCS + 1);

    logic [DATA_W-1:0] max_reg   [NUM_PROCS][NUM_RES];
    logic [DATA_W-1:0] alloc_reg [NUM_PROCS][NUM_RES];
    logic [WORK_W-1:0] work_reg  [NUM_RES];
    logic [PID_W-1:0]  seq_reg   [NUM_PROCS];
    logic [NUM_PROCS-1:0] fin_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [PIDX_W-1:0] p_reg;
    logic [PIDX_W-1:0] k_reg;
    logic              prog_reg;

    logic              result_strobe_reg;
    logic              is_safe_reg;
    logic [PID_W-1:0]  process_id_reg;
    logic              last_reg;

    logic              load_ok;
    logic [PIDX_W-1:0] load_idx;
    logic [NUM_RES-1:0] fits;
    logic              finish_now;
    logic              pass_end;

    // Decode the row written by a load word
    assign load_ok  = ({1'b0, process_index} < (PID_W + 1)'(NUM_PROCS));
    assign load_idx = process_index[PIDX_W-1:0];

    // Compare signed need against the working vector, per resource
    always_comb
    begin
        logic [DATA_W:0]   need9;
        logic [WORK_W:0]   need_ext;
        logic [WORK_W:0]   work_ext;
        for (int r = 0; r < NUM_RES; r++)
        begin
            need9    = {1'b0, max_reg[p_reg][r]} - {1'b0, alloc_reg[p_reg][r]};
            need_ext = {{(WORK_W - DATA_W){need9[DATA_W]}}, need9};
            work_ext = {1'b0, work_reg[r]};
            fits[r]  = !($signed(need_ext) > $signed(work_ext));
        end
    end

    assign finish_now = !fin_reg[p_reg] && (&fits);
    assign pass_end   = (p_reg == PIDX_W'(NUM_PROCS - 1));

    assign status.all_fin   = finish_now && (count_reg == CNT_W'(NUM_PROCS - 1));
    assign status.pass_fail = pass_end && !finish_now && !prog_reg;
    assign status.emit_last = (k_reg == PIDX_W'(NUM_PROCS - 1));

    // Process tables, cleared at reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int p = 0; p < NUM_PROCS; p++)
            begin
                for (int r = 0; r < NUM_RES; r++)
                begin
                    max_reg[p][r]   <= '0;
                    alloc_reg[p][r] <= '0;
                end
            end
        end
        else if (cmd.load && load_ok)
        begin
            for (int r = 0; r < NUM_RES; r++)
            begin
                max_reg[load_idx][r]   <= max_in[r];
                alloc_reg[load_idx][r] <= alloc_in[r];
            end
        end
    end

    // Scan control state: working vector, flags, count, indexes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int r = 0; r < NUM_RES; r++)
            begin
                work_reg[r] <= '0;
            end
            fin_reg   <= '0;
            count_reg <= '0;
            p_reg     <= '0;
            k_reg     <= '0;
            prog_reg  <= 1'b0;
        end
        else if (cmd.init)
        begin
            for (int r = 0; r < NUM_RES; r++)
            begin
                work_reg[r] <= WORK_W'(avail_in[r]);
            end
            fin_reg   <= '0;
            count_reg <= '0;
            p_reg     <= '0;
            k_reg     <= '0;
            prog_reg  <= 1'b0;
        end
        else if (cmd.scan)
        begin
            if (finish_now)
            begin
                for (int r = 0; r < NUM_RES; r++)
                begin
                    work_reg[r] <= work_reg[r] + WORK_W'(alloc_reg[p_reg][r]);
                end
                fin_reg[p_reg] <= 1'b1;
                count_reg      <= count_reg + 1'b1;
            end
            // advance the scan; wrap and drop progress at the end of a pass
            if (pass_end)
            begin
                p_reg    <= '0;
                prog_reg <= 1'b0;
            end
            else
            begin
                p_reg    <= p_reg + 1'b1;
                prog_reg <= prog_reg || finish_now;
            end
        end
        else if (cmd.emit_safe)
        begin
            k_reg <= k_reg + 1'b1;
        end
    end

    // Sequence store, written before it is read
    always_ff @(posedge clk)
    begin
        if (cmd.scan && finish_now)
        begin
            seq_reg[count_reg[PIDX_W-1:0]] <= PID_W'(p_reg);
        end
    end

    // Result strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_strobe_reg <= 1'b0;
        end
        else
        begin
            result_strobe_reg <= cmd.emit_safe || cmd.emit_unsafe;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (cmd.emit_safe)
        begin
            is_safe_reg    <= 1'b1;
            process_id_reg <= seq_reg[k_reg];
            last_reg       <= status.emit_last;
        end
        else if (cmd.emit_unsafe)
        begin
            is_safe_reg    <= 1'b0;
            process_id_reg <= '0;
            last_reg       <= 1'b1;
        end
    end

    assign result_strobe = result_strobe_reg;
    assign is_safe       = is_safe_reg;
    assign process_id    = process_id_reg;
    assign last          = last_reg;

endmodule

### hdl/bsc_checker.sv
// ----------------------------------------------------------------------------
// bsc_checker
// Port-level checks on the safety check block, bound to the top level.
// ----------------------------------------------------------------------------
module bsc_checker (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic                      busy,
    input  logic                      kind,
    input  logic                      result_strobe,
    input  logic                      is_safe,
    input  logic [bsc_pkg::PID_W-1:0] process_id,
    input  logic                      last
);
    import bsc_pkg::*;

    // A check word makes the block busy
    a_check_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (kind == KIND_CHECK)) |=> busy)
        else $error("check word accepted without going busy");

    // A result word follows a busy cycle
    a_result_in_check: assert property (@(posedge clk) disable iff (!rst_n)
        result_strobe |-> $past(busy))
        else $error("result word outside a check");

    // An unsafe word is the only and final word, with a zero id
    a_unsafe_word: assert property (@(posedge clk) disable iff (!rst_n)
        (result_strobe && !is_safe) |-> (last && (process_id == '0)))
        else $error("malformed unsafe word");

    // Nothing follows the final word
    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (result_strobe && last) |=> !result_strobe)
        else $error("result word after the final word");

endmodule

bind bankers_safety_check_top bsc_checker u_bsc_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .kind          (kind),
    .result_strobe (result_strobe),
    .is_safe       (is_safe),
    .process_id    (process_id),
    .last          (last)
);
